### rtl/core/bong_pkg.sv
// Shared constants, codes and interface types of the burst-over-noise generator.
package bong_pkg;

  localparam int CLIP_DEPTH_DEF  = 4096;
  localparam int MAX_OVERLAP_DEF = 2;

  localparam int TW_WORDS = 624;
  localparam int TW_SHIFT = 397;
  localparam int TW_IW    = 10;

  localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] TW_MULT   = 32'd1812433253;
  localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;
  localparam logic [31:0] SEED_DEF  = 32'd5489;

  localparam logic [8:0] NOISE_GAIN = 9'd328;
  localparam logic [9:0] NOISE_BIAS = 10'd164;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [2:0] REG_TOTAL_LEN      = 3'd0;
  localparam logic [2:0] REG_BURST_LEN      = 3'd1;
  localparam logic [2:0] REG_BURST_INTERVAL = 3'd2;
  localparam logic [2:0] REG_START_OFFSET   = 3'd3;
  localparam logic [2:0] REG_NOISE_ENABLE   = 3'd4;
  localparam logic [2:0] REG_NOISE_SEED     = 3'd5;

  typedef struct packed {
    logic        draw;
    logic        restart;
    logic [31:0] seed;
  } tw_req_t;

  typedef struct packed {
    logic valid;
    logic past_end;
    logic is_last;
    logic dropped;
    logic noise;
  } mix_ctl_t;

endpackage

### rtl/core/bong_clip_ram.sv
// One copy of the clip sample store: one write port, one registered read port.
module bong_clip_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [15:0]   wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [15:0]   q
);
  logic [15:0] mem [DEPTH];
  logic [15:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q_r <= mem[ra];
    end
  end

  assign q = q_r;
endmodule

### rtl/core/bong_divider.sv
// Restoring divider, one quotient bit per cycle, for the burst count limit.
module bong_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [23:0] den,
  output logic        busy,
  output logic [23:0] quo
);
  logic [23:0] num_r, num_nxt;
  logic [23:0] den_r;
  logic [24:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r;
  logic [24:0] trial;

  always_comb begin
    trial   = {rem_r[23:0], num_r[23]};
    num_nxt = {num_r[22:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = trial - {1'b0, den_r};
      num_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      num_r <= '0;
    end else if (start) begin
      cnt_r <= 5'd24;
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 5'd1;
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = num_r;
endmodule

### rtl/core/bong_twister.sv
// MT19937 noise source: seeding sweep, in-place twist per draw, tempering.
module bong_twister (
  input  logic             clk,
  input  logic             rst_n,
  input  bong_pkg::tw_req_t req,
  output logic             busy,
  output logic [31:0]      word
);
  import bong_pkg::*;

  typedef enum logic [1:0] {TW_SEED, TW_PREF, TW_RUN} tw_state_t;

  localparam logic [TW_IW:0]   WORDS_W = (TW_IW+1)'(TW_WORDS);
  localparam logic [TW_IW-1:0] LAST_IX = TW_IW'(TW_WORDS - 1);

  tw_state_t       state_r;
  logic [TW_IW-1:0] idx_r, j_r;
  logic [31:0]     p_r, s0_r, w0_r, word_r;
  logic [31:0]     mem [TW_WORDS];
  logic [31:0]     q1_r, qm_r;

  logic            we, re;
  logic [TW_IW-1:0] wa, ra1, ram;
  logic [31:0]     wd;
  logic [31:0]     x, nv, y, v, t1, t2, t3, t4;
  logic [TW_IW:0]  a1, am;

  always_comb begin
    x  = p_r ^ (p_r >> 30);
    nv = 32'(TW_MULT * x) + 32'(j_r);
    y  = {w0_r[31], q1_r[30:0]};
    v  = qm_r ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
    t1 = v ^ (v >> 11);
    t2 = t1 ^ ((t1 << 7) & TEMPER_B);
    t3 = t2 ^ ((t2 << 15) & TEMPER_C);
    t4 = t3 ^ (t3 >> 18);
    a1 = {1'b0, idx_r} + (TW_IW+1)'(2);
    if (a1 >= WORDS_W) a1 = a1 - WORDS_W;
    am = {1'b0, idx_r} + (TW_IW+1)'(TW_SHIFT + 1);
    if (am >= WORDS_W) am = am - WORDS_W;

    we  = 1'b0;
    wa  = idx_r;
    wd  = v;
    re  = 1'b0;
    ra1 = a1[TW_IW-1:0];
    ram = am[TW_IW-1:0];
    case (state_r)
      TW_SEED: begin
        we = 1'b1;
        wa = j_r;
        wd = (j_r == '0) ? p_r : nv;
      end
      TW_PREF: begin
        re  = 1'b1;
        ra1 = TW_IW'(1);
        ram = TW_IW'(TW_SHIFT);
      end
      TW_RUN: begin
        we = req.draw;
        re = req.draw;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q1_r <= mem[ra1];
      qm_r <= mem[ram];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TW_SEED;
      j_r     <= '0;
      p_r     <= SEED_DEF;
      s0_r    <= SEED_DEF;
      idx_r   <= '0;
    end else begin
      case (state_r)
        TW_SEED: begin
          if (j_r != '0) p_r <= nv;
          if (j_r == LAST_IX) begin
            state_r <= TW_PREF;
          end else begin
            j_r <= j_r + TW_IW'(1);
          end
        end
        TW_PREF: begin
          w0_r    <= s0_r;
          idx_r   <= '0;
          state_r <= TW_RUN;
        end
        TW_RUN: begin
          if (req.restart) begin
            state_r <= TW_SEED;
            j_r     <= '0;
            p_r     <= req.seed;
            s0_r    <= req.seed;
          end else if (req.draw) begin
            w0_r   <= q1_r;
            word_r <= t4;
            idx_r  <= (idx_r == LAST_IX) ? '0 : idx_r + TW_IW'(1);
          end
        end
        default: state_r <= TW_SEED;
      endcase
    end
  end

  assign busy = (state_r != TW_RUN);
  assign word = word_r;
endmodule

### rtl/core/bong_mixer.sv
// Noise scaling, burst sum, saturation and the result register.
module bong_mixer #(
  parameter int MAX_OVERLAP = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  bong_pkg::mix_ctl_t               b_ctl,
  input  logic [MAX_OVERLAP-1:0]           b_act,
  input  logic [31:0]                      word,
  input  logic [MAX_OVERLAP-1:0][15:0]     clip_q,
  output logic                             out_valid,
  output logic signed [15:0]               sample_out,
  output logic                             is_last,
  output logic                             past_end,
  output logic                             overlap_dropped
);
  import bong_pkg::*;

  localparam int SW = 16 + $clog2(MAX_OVERLAP + 1);
  localparam int AW = SW + 2;

  mix_ctl_t        c_ctl_r;
  logic [24:0]     prod_r;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [AW-1:0] acc;
  logic [9:0]      nz;
  logic            vld_r, last_r, past_r, drop_r;
  logic signed [15:0] smp_r;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < MAX_OVERLAP; k++) begin
      if (b_act[k]) sum_nxt = sum_nxt + SW'($signed(clip_q[k]));
    end
    nz  = {1'b0, prod_r[24:16]} - NOISE_BIAS;
    acc = AW'(sum_r) + (c_ctl_r.noise ? AW'($signed(nz)) : AW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
      vld_r   <= 1'b0;
    end else if (advance) begin
      c_ctl_r <= b_ctl;
      prod_r  <= 25'(word[31:16] * NOISE_GAIN);
      sum_r   <= sum_nxt;
      vld_r   <= c_ctl_r.valid;
      last_r  <= c_ctl_r.is_last;
      past_r  <= c_ctl_r.past_end;
      drop_r  <= c_ctl_r.dropped;
      if (c_ctl_r.past_end) smp_r <= '0;
      else if (acc > AW'(32767)) smp_r <= 16'sd32767;
      else if (acc < -AW'(32768)) smp_r <= -16'sd32768;
      else smp_r <= acc[15:0];
    end
  end

  assign out_valid       = vld_r;
  assign sample_out      = smp_r;
  assign is_last         = last_r;
  assign past_end        = past_r;
  assign overlap_dropped = drop_r;
endmodule

### rtl/core/burst_over_noise_stimulus_generator_top.sv
// Top level of the periodic tone-burst generator over a noise floor.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | in_kind, in_sample_in
//  out     | output    | out_valid/out_ready | out_sample_out, out_is_last, out_past_end,
//          |           |                     | out_overlap_dropped
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// One beat a cycle is taken while in_ready is high; a tick's result passes through the
// clip read and noise draw, then the multiply and burst sum, then the saturating add.
// After reset and after each restart beat the twister seeding sweep writes its
// 624 words, then runs a prefetch, with in_ready low.
// A write of total_len or burst_interval holds in_ready low
// while the burst count limit is divided out.
// A stalled result freezes the whole pipe; new beats wait until it drains.
module burst_over_noise_stimulus_generator_top #(
  parameter int CLIP_DEPTH  = bong_pkg::CLIP_DEPTH_DEF,
  parameter int MAX_OVERLAP = bong_pkg::MAX_OVERLAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic               out_is_last,
  output logic               out_past_end,
  output logic               out_overlap_dropped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import bong_pkg::*;

  localparam int AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int CW = $clog2(CLIP_DEPTH + 1);

  // configuration registers
  logic [23:0] total_len_r, burst_interval_r, start_offset_r;
  logic [15:0] burst_len_r;
  logic        noise_en_r;
  logic [31:0] seed_r;

  // generator state
  logic [CW-1:0] count_r, count_nxt;
  logic [23:0]   si_r, si_nxt;
  logic [24:0]   ns_r, ns_nxt;
  logic [23:0]   bs_r, bs_nxt;
  logic [MAX_OVERLAP-1:0] act_r, act_nxt, act_w;
  logic [15:0]   pos_r [MAX_OVERLAP];
  logic [15:0]   pos_nxt [MAX_OVERLAP];
  logic [15:0]   pos_w [MAX_OVERLAP];
  logic [AW-1:0] rp_r [MAX_OVERLAP];
  logic [AW-1:0] rp_nxt [MAX_OVERLAP];
  logic [AW-1:0] rp_w [MAX_OVERLAP];

  // stage B
  mix_ctl_t               b_ctl_r;
  logic [MAX_OVERLAP-1:0] b_act_r;

  logic acc_in, advance, is_load, is_tick, is_restart, tick_live, draw;
  logic start_hit, keep, placed, dropped, clip_we, div_busy, tw_busy;
  logic div_start;
  logic [23:0] div_num, div_den, limit;
  logic [31:0] tw_word;
  logic [16:0] pos_p;
  logic [CW:0] rp_p;
  tw_req_t tw_req;
  logic [MAX_OVERLAP-1:0][15:0] clip_q;

  assign advance    = !out_valid || out_ready;
  assign in_ready   = advance && !tw_busy && !div_busy;
  assign acc_in     = in_valid && in_ready;
  assign is_load    = (in_kind == KIND_LOAD);
  assign is_tick    = (in_kind == KIND_TICK);
  assign is_restart = (in_kind == KIND_RESTART);
  assign tick_live  = acc_in && is_tick && (si_r < total_len_r);
  assign draw       = tick_live && noise_en_r;
  assign clip_we    = acc_in && is_load && (count_r < CW'(CLIP_DEPTH));

  // a burst is due here, and it is kept when it fits before the end
  assign start_hit = (burst_interval_r != '0) && (bs_r < limit) && ({1'b0, si_r} == ns_r);
  assign keep = (count_r != '0) && (burst_len_r != '0) &&
                (({1'b0, si_r} + {9'd0, burst_len_r}) < {1'b0, total_len_r});

  always_comb begin
    count_nxt = count_r;
    si_nxt    = si_r;
    ns_nxt    = ns_r;
    bs_nxt    = bs_r;
    act_w     = act_r;
    pos_w     = pos_r;
    rp_w      = rp_r;
    placed    = 1'b0;
    dropped   = 1'b0;
    pos_p     = '0;
    rp_p      = '0;
    if (clip_we) count_nxt = count_r + CW'(1);

    // place a new burst in the first free slot, or drop it
    if (tick_live && start_hit) begin
      bs_nxt = bs_r + 24'd1;
      ns_nxt = ns_r + {1'b0, burst_interval_r};
      if (keep) begin
        for (int k = 0; k < MAX_OVERLAP; k++) begin
          if (!placed && !act_r[k]) begin
            act_w[k] = 1'b1;
            pos_w[k] = '0;
            rp_w[k]  = '0;
            placed   = 1'b1;
          end
        end
        dropped = !placed;
      end
    end

    act_nxt = act_w;
    pos_nxt = pos_w;
    rp_nxt  = rp_w;
    if (tick_live) begin
      si_nxt = si_r + 24'd1;
      // advance every playing slot, wrap its read pointer, retire it at burst end
      for (int k = 0; k < MAX_OVERLAP; k++) begin
        if (act_w[k]) begin
          pos_p      = {1'b0, pos_w[k]} + 17'd1;
          rp_p       = (CW+1)'(rp_w[k]) + (CW+1)'(1);
          pos_nxt[k] = pos_p[15:0];
          rp_nxt[k]  = (rp_p >= {1'b0, count_r}) ? '0 : rp_p[AW-1:0];
          if (pos_p >= {1'b0, burst_len_r}) act_nxt[k] = 1'b0;
        end
      end
    end

    if (acc_in && is_restart) begin
      si_nxt  = '0;
      ns_nxt  = {1'b0, start_offset_r};
      bs_nxt  = '0;
      act_nxt = '0;
      for (int k = 0; k < MAX_OVERLAP; k++) begin
        pos_nxt[k] = '0;
        rp_nxt[k]  = '0;
      end
    end
  end

  // configuration writes; a new total length or burst interval reruns the limit divide
  assign div_start = cfg_we && ((cfg_index == REG_TOTAL_LEN) ||
                                (cfg_index == REG_BURST_INTERVAL));
  assign div_num = (cfg_index == REG_TOTAL_LEN) ? cfg_wdata[23:0] : total_len_r;
  assign div_den = (cfg_index == REG_BURST_INTERVAL) ? cfg_wdata[23:0] : burst_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r      <= '0;
      burst_len_r      <= '0;
      burst_interval_r <= 24'd1;
      start_offset_r   <= '0;
      noise_en_r       <= 1'b0;
      seed_r           <= SEED_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_LEN:      total_len_r      <= cfg_wdata[23:0];
        REG_BURST_LEN:      burst_len_r      <= cfg_wdata[15:0];
        REG_BURST_INTERVAL: burst_interval_r <= cfg_wdata[23:0];
        REG_START_OFFSET:   start_offset_r   <= cfg_wdata[23:0];
        REG_NOISE_ENABLE:   noise_en_r       <= cfg_wdata[0];
        REG_NOISE_SEED:     seed_r           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      si_r    <= '0;
      ns_r    <= '0;
      bs_r    <= '0;
      act_r   <= '0;
      b_ctl_r <= '0;
      b_act_r <= '0;
      for (int k = 0; k < MAX_OVERLAP; k++) begin
        pos_r[k] <= '0;
        rp_r[k]  <= '0;
      end
    end else begin
      count_r <= count_nxt;
      si_r    <= si_nxt;
      ns_r    <= ns_nxt;
      bs_r    <= bs_nxt;
      act_r   <= act_nxt;
      pos_r   <= pos_nxt;
      rp_r    <= rp_nxt;
      // hold stage B while the result register is stalled
      if (advance) begin
        b_ctl_r.valid    <= acc_in && is_tick;
        b_ctl_r.past_end <= acc_in && is_tick && !tick_live;
        b_ctl_r.is_last  <= tick_live && (({1'b0, si_r} + 25'd1) == {1'b0, total_len_r});
        b_ctl_r.dropped  <= dropped;
        b_ctl_r.noise    <= draw;
        b_act_r          <= tick_live ? act_w : '0;
      end
    end
  end

  assign tw_req.draw    = draw;
  assign tw_req.restart = acc_in && is_restart;
  assign tw_req.seed    = seed_r;

  bong_twister u_twister (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (tw_req),
    .busy (tw_busy),
    .word (tw_word)
  );

  bong_divider u_divider (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (limit)
  );

  // one clip copy per slot so every slot reads in the same cycle
  for (genvar g = 0; g < MAX_OVERLAP; g++) begin : g_clip
    bong_clip_ram #(
      .DEPTH(CLIP_DEPTH),
      .AW   (AW)
    ) u_clip (
      .clk(clk),
      .we (clip_we),
      .wa (count_r[AW-1:0]),
      .wd (in_sample_in),
      .re (tick_live),
      .ra (rp_w[g]),
      .q  (clip_q[g])
    );
  end

  bong_mixer #(
    .MAX_OVERLAP(MAX_OVERLAP)
  ) u_mixer (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .b_ctl          (b_ctl_r),
    .b_act          (b_act_r),
    .word           (tw_word),
    .clip_q         (clip_q),
    .out_valid      (out_valid),
    .sample_out     (out_sample_out),
    .is_last        (out_is_last),
    .past_end       (out_past_end),
    .overlap_dropped(out_overlap_dropped)
  );
endmodule

### rtl/core/bong_checker.sv
// Port-level checks of the generator, bound to the top level.
module bong_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample_out,
  input logic               out_is_last,
  input logic               out_past_end,
  input logic               out_overlap_dropped
);
  a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_past_end |-> out_sample_out == 16'sd0 && !out_is_last
                                   && !out_overlap_dropped)
    else $error("past-end beat carries data");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_seed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during seeding after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");
endmodule

bind burst_over_noise_stimulus_generator_top bong_checker u_bong_checker (.*);

### test/tb.sv
// Testbench for the tone-burst generator over a noise floor: directed and random beats.
`timescale 1ns / 100ps

module tb;
  import bong_pkg::*;

  localparam int CLIP_N = 4096;
  localparam int SLOTS  = 2;
  localparam int LIMIT  = 200000;

  localparam logic [1:0] KIND_NONE = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = KIND_TICK;
  logic signed [15:0] in_sample_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample_out;
  logic               out_is_last;
  logic               out_past_end;
  logic               out_overlap_dropped;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_TOTAL_LEN;
  logic [31:0]        cfg_wdata = '0;

  burst_over_noise_stimulus_generator_top dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               past;
    logic               dropped;
  } tone_t;

  // Predictor state, mirrors the block's registers and memories.
  logic [23:0] p_total, p_interval, p_offset;
  logic [15:0] p_blen;
  logic        p_noise;
  logic [31:0] p_seed;
  logic [15:0] p_clip [CLIP_N];
  int unsigned p_count, p_index, p_next, p_started;
  int unsigned p_pos [SLOTS];
  int unsigned p_ptr [SLOTS];
  bit          p_act [SLOTS];
  logic [31:0] mt [624];
  int unsigned mt_idx;

  tone_t       tone_q[$];
  int          errors = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  function automatic void mt_seed(logic [31:0] s);
    logic [31:0] p;
    mt[0] = s;
    for (int i = 1; i < 624; i++) begin
      p = mt[i-1];
      mt[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
    end
    mt_idx = 624;
  endfunction

  function automatic logic [31:0] mt_word();
    logic [31:0] y, v;
    if (mt_idx >= 624) begin
      for (int i = 0; i < 624; i++) begin
        y = (mt[i] & 32'h8000_0000) | (mt[(i+1)%624] & 32'h7FFF_FFFF);
        v = mt[(i+397)%624] ^ (y >> 1);
        if (y[0]) v ^= 32'h9908_B0DF;
        mt[i] = v;
      end
      mt_idx = 0;
    end
    y = mt[mt_idx];
    mt_idx++;
    y ^= y >> 11;
    y ^= (y << 7) & 32'h9D2C_5680;
    y ^= (y << 15) & 32'hEFC6_0000;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic void rearm();
    mt_seed(p_seed);
    p_index = 0; p_next = 32'(p_offset); p_started = 0;
    for (int k = 0; k < SLOTS; k++) begin
      p_pos[k] = 0; p_ptr[k] = 0; p_act[k] = 0;
    end
  endfunction

  // Advance the predictor by one accepted beat; queue a tone sample for ticks.
  function automatic void predict_beat(logic [1:0] kind, logic [15:0] smp);
    tone_t r;
    int acc, ln;
    bit placed;
    logic [31:0] u;
    r = '0;
    if (kind == KIND_LOAD) begin
      if (p_count < CLIP_N) begin p_clip[p_count] = smp; p_count++; end
      return;
    end
    if (kind == KIND_RESTART) begin rearm(); return; end
    if (kind != KIND_TICK) return;
    if (p_index >= p_total) begin
      r.past = 1'b1;
      tone_q.push_back(r);
      return;
    end
    acc = 0;
    if (p_noise) begin
      u = mt_word() >> 16;
      acc = int'((u * 328) >> 16) - 164;
    end
    if (p_interval != 0 && p_started < p_total / p_interval && p_index == p_next) begin
      ln = (p_count == 0) ? 0 : int'(p_blen);
      p_started++;
      p_next += p_interval;
      if (ln != 0 && longint'(p_index) + ln < longint'(p_total)) begin
        placed = 0;
        for (int k = 0; k < SLOTS && !placed; k++)
          if (!p_act[k]) begin
            p_act[k] = 1; p_pos[k] = 0; p_ptr[k] = 0; placed = 1;
          end
        if (!placed) r.dropped = 1'b1;
      end
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (!p_act[k]) continue;
      acc += int'($signed(p_clip[p_ptr[k] % CLIP_N]));
      p_pos[k]++; p_ptr[k]++;
      if (p_ptr[k] >= p_count) p_ptr[k] = 0;
      if (p_pos[k] >= p_blen) p_act[k] = 0;
    end
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    r.sample = acc[15:0];
    r.last = (p_index + 1 == p_total);
    p_index++;
    tone_q.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (sample %0d)", what, got, want, n_checked);
  endtask

  // Hold the beat until accepted, with random sender gaps before it.
  // Valid stays up after acceptance; the next call or settle() drops it.
  task automatic send_beat(logic [1:0] kind, logic [15:0] smp);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(kind, smp);
    n_sent++;
  endtask

  // Drain expected tones, then let the pipe settle before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after its last write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TOTAL_LEN:      p_total = val[23:0];
      REG_BURST_LEN:      p_blen = val[15:0];
      REG_BURST_INTERVAL: p_interval = val[23:0];
      REG_START_OFFSET:   p_offset = val[23:0];
      REG_NOISE_ENABLE:   p_noise = val[0];
      REG_NOISE_SEED:     p_seed = val;
      default: ;
    endcase
  endtask

  task automatic setup(int tl, int bl, int bi, int so, bit ne, logic [31:0] sd);
    settle();
    write_reg(REG_TOTAL_LEN, tl);
    write_reg(REG_BURST_LEN, bl);
    write_reg(REG_BURST_INTERVAL, bi);
    write_reg(REG_START_OFFSET, so);
    write_reg(REG_NOISE_ENABLE, {31'd0, ne});
    write_reg(REG_NOISE_SEED, sd);
    cfg_we <= 1'b0;
    send_beat(KIND_RESTART, '0);
  endtask

  // Compare each result beat with the oldest expected tone.
  always @(posedge clk) begin
    tone_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (tone_q.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        w = tone_q.pop_front();
        if (out_sample_out !== w.sample) report("sample_out", out_sample_out, w.sample);
        if (out_is_last !== w.last) report("is_last", out_is_last, w.last);
        if (out_past_end !== w.past) report("past_end", out_past_end, w.past);
        if (out_overlap_dropped !== w.dropped)
          report("overlap_dropped", out_overlap_dropped, w.dropped);
        n_checked++;
      end
    end
    out_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk)
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end

  task automatic test_reset_state();
    // Defaults: total_len 0, so any tick lands past the end.
    send_beat(KIND_TICK, '0);
    send_beat(KIND_NONE, 16'h7FFF);
  endtask

  task automatic test_directed();
    // Fill a short clip with extremes, then hit overlap, saturation and the end.
    send_beat(KIND_LOAD, 16'h7FFF);
    send_beat(KIND_LOAD, 16'h8000);
    send_beat(KIND_LOAD, 16'h7FFF);
    setup(12, 5, 1, 0, 1'b0, 32'd0);
    repeat (14) send_beat(KIND_TICK, '0);
    setup(6, 0, 2, 1, 1'b1, 32'hFFFF_FFFF);
    repeat (7) send_beat(KIND_TICK, 16'hFFFF);
    setup(10, 65535, 0, 0, 1'b1, 32'd5489);
    repeat (3) send_beat(KIND_TICK, '0);
  endtask

  task automatic test_random(int beats, int idle, int stall);
    int tl, r;
    send_idle = idle; recv_stall = stall;
    tl = $urandom_range(60, 4);
    setup(tl, $urandom_range(12), $urandom_range(8, 1), $urandom_range(6),
          1'($urandom_range(1)), $urandom());
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      if (r < 8 && p_count < 64)
        send_beat(KIND_LOAD, 16'($urandom()));
      else if (r < 10)
        send_beat(KIND_RESTART, '0);
      else if (r < 11)
        send_beat(KIND_NONE, 16'($urandom()));
      else
        send_beat(KIND_TICK, 16'($urandom()));
    end
    // Finish by pushing the far extremes of the registers.
    setup(16777215, 65535, 16777215, 16777215, 1'b1, $urandom());
    repeat (5) send_beat(KIND_TICK, '0);
  endtask

  task automatic test_long_burst();
    // Two long overlapping bursts whose read pointers wrap over the clip.
    send_idle = 0; recv_stall = 0;
    setup(200, 150, 40, 3, 1'b1, 32'd7);
    repeat (100) send_beat(KIND_TICK, '0);
  endtask

  initial begin
    p_total = 0; p_blen = 0; p_interval = 1; p_offset = 0; p_noise = 0;
    p_seed = 32'd5489; p_count = 0;
    for (int i = 0; i < CLIP_N; i++) p_clip[i] = '0;
    rearm();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed();
    for (int ph = 0; ph < 8; ph++)
      case (ph % 4)
        0: test_random(110, 0, 0);
        1: test_random(110, 60, 0);
        2: test_random(110, 0, 60);
        default: test_random(110, 29, 29);
      endcase
    test_long_burst();
    send_idle = 0; recv_stall = 0;
    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d input beats and %0d checked result beats.", n_sent, n_checked);
    $display("Phases swept idle and stall mixes, overlap, saturation and long wrapping bursts.");
    if (errors == 0 && tone_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
